FILE: hw/rtl/sfdc_pkg.sv
// Shared types and constants for the sphere frustum distance cull block.
// Holds the item record that travels down the pipeline and the clip class codes.
// No dependencies; every other file of the block refers to it by scoped names.
package sfdc_pkg;

   localparam int NUM_PLANES_DEFAULT = 6;
   localparam int COORD_BITS_DEFAULT = 21;

   localparam int CENTER_BITS = 21;
   localparam int RADIUS_BITS = 20;
   localparam int NORMAL_BITS = 14;
   localparam int OFFSET_BITS = 22;
   localparam int FRAC_BITS = 12;
   localparam int PLANE_BITS = 64;
   localparam int CAMERA_BITS = 63;
   localparam int DRAW_BITS = 44;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam int REQ_DATA_BITS = 88;
   localparam int RSP_DATA_BITS = 8;

   // Signed distance to a plane in Q.12, and the product of one normal by one coordinate.
   localparam int PROD_BITS = NORMAL_BITS + CENTER_BITS;
   localparam int DIST_BITS = PROD_BITS + 3;

   // Camera distance arithmetic.
   localparam int DELTA_BITS = CENTER_BITS + 1;
   localparam int SQUARE_BITS = 2 * DELTA_BITS;
   localparam int RSQ_BITS = 2 * RADIUS_BITS;
   localparam int RANGE_BITS = DRAW_BITS + 2;

   localparam logic [1:0] CLASS_INSIDE = 2'd0;
   localparam logic [1:0] CLASS_CROSSING = 2'd1;
   localparam logic [1:0] CLASS_OUTSIDE = 2'd2;

   typedef struct packed {
      logic signed [CENTER_BITS-1:0] cx;
      logic signed [CENTER_BITS-1:0] cy;
      logic signed [CENTER_BITS-1:0] cz;
      logic [RADIUS_BITS-1:0] radius;
      logic in_range;
      logic outside;
      logic crossing;
   } item_type;

endpackage

FILE: hw/rtl/sfdc_range.sv
// Camera range test: three pipeline stages computing |c - cam|^2 - r^2 against the limit.
// Depends on sfdc_pkg for the item record and the arithmetic widths.
// Sets the in_range flag of each item and passes it on to the plane cells.
module sfdc_range (
   input  logic clock,
   input  logic reset,
   input  logic signed [sfdc_pkg::CENTER_BITS-1:0] cam_x,
   input  logic signed [sfdc_pkg::CENTER_BITS-1:0] cam_y,
   input  logic signed [sfdc_pkg::CENTER_BITS-1:0] cam_z,
   input  logic [sfdc_pkg::DRAW_BITS-1:0] draw_sq,
   input  logic in_valid,
   output logic in_ready,
   input  sfdc_pkg::item_type in_item,
   output logic out_valid,
   input  logic out_ready,
   output sfdc_pkg::item_type out_item
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic rdy1, rdy2, rdy3;
   sfdc_pkg::item_type s1_item_ff, s2_item_ff, s3_item_ff;
   logic signed [sfdc_pkg::DELTA_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [sfdc_pkg::DELTA_BITS-1:0] dx_in, dy_in, dz_in;
   logic signed [sfdc_pkg::SQUARE_BITS-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic signed [sfdc_pkg::SQUARE_BITS-1:0] sqx_in, sqy_in, sqz_in;
   logic [sfdc_pkg::RSQ_BITS-1:0] rsq_ff, rsq_in;
   logic signed [sfdc_pkg::RANGE_BITS-1:0] dist_in, limit;
   sfdc_pkg::item_type s3_item_in;

   assign rdy3 = !s3_valid_ff || out_ready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      dx_in = sfdc_pkg::DELTA_BITS'(in_item.cx) - sfdc_pkg::DELTA_BITS'(cam_x);
      dy_in = sfdc_pkg::DELTA_BITS'(in_item.cy) - sfdc_pkg::DELTA_BITS'(cam_y);
      dz_in = sfdc_pkg::DELTA_BITS'(in_item.cz) - sfdc_pkg::DELTA_BITS'(cam_z);
      sqx_in = dx_ff * dx_ff;
      sqy_in = dy_ff * dy_ff;
      sqz_in = dz_ff * dz_ff;
      rsq_in = s1_item_ff.radius * s1_item_ff.radius;
      dist_in = sfdc_pkg::RANGE_BITS'(sqx_ff) + sfdc_pkg::RANGE_BITS'(sqy_ff)
              + sfdc_pkg::RANGE_BITS'(sqz_ff)
              - $signed({{(sfdc_pkg::RANGE_BITS - sfdc_pkg::RSQ_BITS){1'b0}}, rsq_ff});
      limit = $signed({{(sfdc_pkg::RANGE_BITS - sfdc_pkg::DRAW_BITS){1'b0}}, draw_sq});
      s3_item_in = s2_item_ff;
      s3_item_in.in_range = dist_in < limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= in_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_item_ff <= in_item;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sqz_ff <= sqz_in;
         rsq_ff <= rsq_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item = s3_item_ff;

endmodule

FILE: hw/rtl/sfdc_cell.sv
// One plane cell of the culling chain: two stages, products then sum and compare.
// Depends on sfdc_pkg for the item record and widths.
// Folds this plane's outside and crossing verdicts into the flags of the passing item.
module sfdc_cell (
   input  logic clock,
   input  logic reset,
   input  logic [sfdc_pkg::PLANE_BITS-1:0] plane,
   input  logic in_valid,
   output logic in_ready,
   input  sfdc_pkg::item_type in_item,
   output logic out_valid,
   input  logic out_ready,
   output sfdc_pkg::item_type out_item
);

   localparam int NB = sfdc_pkg::NORMAL_BITS;
   localparam int DB = sfdc_pkg::DIST_BITS;

   logic s1_valid_ff, s2_valid_ff;
   logic rdy1, rdy2;
   sfdc_pkg::item_type s1_item_ff, s2_item_ff, s2_item_in;
   logic signed [NB-1:0] nx, ny, nz;
   logic signed [sfdc_pkg::OFFSET_BITS-1:0] offset;
   logic signed [sfdc_pkg::PROD_BITS-1:0] px_ff, py_ff, pz_ff;
   logic signed [sfdc_pkg::PROD_BITS-1:0] px_in, py_in, pz_in;
   logic signed [DB-1:0] plane_dist, rq;
   logic below_neg, below_pos;

   assign nx = plane[NB-1:0];
   assign ny = plane[2*NB-1:NB];
   assign nz = plane[3*NB-1:2*NB];
   assign offset = plane[3*NB+sfdc_pkg::OFFSET_BITS-1:3*NB];

   assign rdy2 = !s2_valid_ff || out_ready;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      px_in = nx * in_item.cx;
      py_in = ny * in_item.cy;
      pz_in = nz * in_item.cz;
      plane_dist = DB'(px_ff) + DB'(py_ff) + DB'(pz_ff)
                 + (DB'(offset) <<< sfdc_pkg::FRAC_BITS);
      rq = $signed({{(DB - sfdc_pkg::RADIUS_BITS - sfdc_pkg::FRAC_BITS){1'b0}},
                    s1_item_ff.radius, {sfdc_pkg::FRAC_BITS{1'b0}}});
      below_neg = plane_dist < -rq;
      below_pos = plane_dist < rq;
      s2_item_in = s1_item_ff;
      s2_item_in.outside = s1_item_ff.outside || below_neg;
      s2_item_in.crossing = s1_item_ff.crossing || (!below_neg && below_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= in_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_item_ff <= in_item;
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item = s2_item_ff;

endmodule

FILE: hw/rtl/sphere_frustum_distance_cull.sv
// Sphere frustum and draw distance cull: top level with register file and cell chain.
// Depends on sfdc_pkg, sfdc_range and sfdc_cell.
//
// Usage. Each request on the req_ stream carries one bounding sphere (centre and radius).
// The block returns exactly one response per request on the rsp_ stream, in order,
// giving the frustum clip class, the draw range flag and the combined visible flag.
// Planes, camera position and squared draw distance are written on the csr_ channel,
// which is always ready; index i selects plane i, NUM_PLANES the camera and
// NUM_PLANES+1 the draw limit. Unknown indices are dropped. Write them only while idle.
//
// A request passes three stages of the range unit, then two stages in each plane cell
// of the chain. Throughput is one request per cycle unless the receiver stalls; each
// stage holds one request and hands it on to its neighbour whenever that stage is empty or
// moving. When the receiver stalls, the final cell holds its response and the stall
// spreads back stage by stage, so requests are still taken while any stage further down
// holds a bubble. Reset is synchronous, empties every stage and clears the register file
// to zero: all-zero planes make a sphere of nonzero radius crossing and one of zero radius
// inside.
module sphere_frustum_distance_cull #(
   parameter int NUM_PLANES = sfdc_pkg::NUM_PLANES_DEFAULT,
   parameter int COORD_BITS = sfdc_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // Request: center_x [20:0], center_y [41:21], center_z [62:42], radius [82:63].
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [sfdc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // Response: clip_class [1:0], in_range [2], visible [3].
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [sfdc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // Register writes.
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sfdc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfdc_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int CB = sfdc_pkg::CENTER_BITS;
   localparam int IB = sfdc_pkg::CSR_INDEX_BITS;
   localparam logic [IB-1:0] IDX_CAMERA = IB'(NUM_PLANES);
   localparam logic [IB-1:0] IDX_DRAW = IB'(NUM_PLANES + 1);

   logic [sfdc_pkg::PLANE_BITS-1:0] plane_ff [NUM_PLANES];
   logic [sfdc_pkg::CAMERA_BITS-1:0] camera_ff;
   logic [sfdc_pkg::DRAW_BITS-1:0] draw_ff;

   logic signed [COORD_BITS-1:0] cx_raw, cy_raw, cz_raw;
   logic signed [COORD_BITS-1:0] camx_raw, camy_raw, camz_raw;
   logic signed [CB-1:0] cam_x, cam_y, cam_z;
   sfdc_pkg::item_type req_item;

   sfdc_pkg::item_type chain_item [NUM_PLANES+1];
   logic chain_valid [NUM_PLANES+1];
   logic chain_ready [NUM_PLANES+1];
   sfdc_pkg::item_type last_item;
   logic [1:0] clip_class;

   // Register file; the channel never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) plane_ff[i] <= '0;
         camera_ff <= '0;
         draw_ff <= '0;
      end else if (csr_valid) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            if (csr_index == IB'(i)) plane_ff[i] <= csr_data;
         end
         if (csr_index == IDX_CAMERA) camera_ff <= csr_data[sfdc_pkg::CAMERA_BITS-1:0];
         if (csr_index == IDX_DRAW) draw_ff <= csr_data[sfdc_pkg::DRAW_BITS-1:0];
      end
   end

   // Coordinates narrower than the field are sign-extended from their low bits.
   assign cx_raw = req_tdata[COORD_BITS-1:0];
   assign cy_raw = req_tdata[CB+COORD_BITS-1:CB];
   assign cz_raw = req_tdata[2*CB+COORD_BITS-1:2*CB];
   assign camx_raw = camera_ff[COORD_BITS-1:0];
   assign camy_raw = camera_ff[2*COORD_BITS-1:COORD_BITS];
   assign camz_raw = camera_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign cam_x = CB'(camx_raw);
   assign cam_y = CB'(camy_raw);
   assign cam_z = CB'(camz_raw);

   always_comb begin
      req_item.cx = CB'(cx_raw);
      req_item.cy = CB'(cy_raw);
      req_item.cz = CB'(cz_raw);
      req_item.radius = req_tdata[3*CB+sfdc_pkg::RADIUS_BITS-1:3*CB];
      req_item.in_range = 1'b0;
      req_item.outside = 1'b0;
      req_item.crossing = 1'b0;
   end

   sfdc_range u_range (
      .clock     (clock),
      .reset     (reset),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .cam_z     (cam_z),
      .draw_sq   (draw_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_item  (chain_item[0])
   );

   // One cell per plane; each cell passes the request on to the next.
   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_chain
      sfdc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (plane_ff[k]),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   assign chain_ready[NUM_PLANES] = rsp_tready;
   assign last_item = chain_item[NUM_PLANES];

   // Outside on any plane dominates crossing.
   always_comb begin
      if (last_item.outside) clip_class = sfdc_pkg::CLASS_OUTSIDE;
      else if (last_item.crossing) clip_class = sfdc_pkg::CLASS_CROSSING;
      else clip_class = sfdc_pkg::CLASS_INSIDE;
   end

   assign rsp_tvalid = chain_valid[NUM_PLANES];
   assign rsp_tdata = {{(sfdc_pkg::RSP_DATA_BITS - 4){1'b0}},
                       last_item.in_range && !last_item.outside,
                       last_item.in_range, clip_class};

endmodule

FILE: hw/rtl/sfdc_checker.sv
// Port-level checks for the sphere frustum distance cull block, and their bind.
// Depends on sfdc_pkg for the response layout and clip class codes.
// Sees only the top level's ports.
module sfdc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [sfdc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic csr_ready
);

   // A response never carries the unused clip class code.
   a_class_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == sfdc_pkg::CLASS_INSIDE
                   || rsp_tdata[1:0] == sfdc_pkg::CLASS_CROSSING
                   || rsp_tdata[1:0] == sfdc_pkg::CLASS_OUTSIDE))
      else $error("clip class out of range");

   // Visible requires the draw range test and a class other than outside.
   a_visible : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |->
         (rsp_tdata[2] && rsp_tdata[1:0] != sfdc_pkg::CLASS_OUTSIDE))
      else $error("visible set without range or while outside");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response present right after reset");

   // A stalled response is held unchanged.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // The register channel never pushes back outside reset.
   a_csr_ready : assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register channel not ready");

endmodule

bind sphere_frustum_distance_cull sfdc_checker u_sfdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

FILE: bench/tb.sv
// Self-checking bench for sphere_frustum_distance_cull: frustum class and draw range per sphere.
// Depends on sfdc_pkg and the block's RTL. Spheres stream in on req_, verdicts are
// checked on rsp_ against a predictor of its own, and registers are written on csr_.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PLANES = sfdc_pkg::NUM_PLANES_DEFAULT;
   localparam int IB = sfdc_pkg::CSR_INDEX_BITS;
   localparam int CB = sfdc_pkg::CENTER_BITS;
   localparam int RB = sfdc_pkg::RADIUS_BITS;
   localparam int NB = sfdc_pkg::NORMAL_BITS;
   localparam int OB = sfdc_pkg::OFFSET_BITS;
   localparam int DATA_BITS = sfdc_pkg::CSR_DATA_BITS;
   // The pause after draining covers the depth of the pipeline and adds a margin.
   localparam int SETTLE = 3 + 2 * PLANES + 5;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SPHERES = 250;

   // Register indexes: one per plane, then the camera and the draw limit.
   // Indexes beyond the draw limit are unmapped and must be dropped by the block.
   localparam logic [IB-1:0] CSR_PLANE_FIRST = '0;
   localparam logic [IB-1:0] CSR_CAMERA = IB'(PLANES);
   localparam logic [IB-1:0] CSR_DRAW_LIMIT = IB'(PLANES + 1);
   localparam logic [IB-1:0] CSR_UNMAPPED_FIRST = IB'(PLANES + 2);
   localparam logic [IB-1:0] CSR_UNMAPPED_LAST = '1;

   // Unit normal component in Q1.12.
   localparam int UNIT_NORMAL = 1 << sfdc_pkg::FRAC_BITS;

   typedef struct {
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic signed [CB-1:0] cz;
      logic [RB-1:0] radius;
   } sphere_type;

   typedef struct {
      logic [1:0] clip_class;
      logic in_range;
      logic visible;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [sfdc_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [sfdc_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IB-1:0] csr_index = '0;
   logic [DATA_BITS-1:0] csr_data = '0;

   // The bench's own copy of the register file, updated on each accepted write.
   logic [sfdc_pkg::PLANE_BITS-1:0] plane_cfg [PLANES];
   logic [sfdc_pkg::CAMERA_BITS-1:0] camera_cfg;
   logic [sfdc_pkg::DRAW_BITS-1:0] draw_cfg;

   sphere_type spheres_to_send [$];
   verdict_type verdicts_due [$];
   sphere_type sphere_on_bus;
   verdict_type verdict_head;

   int spheres_queued = 0;
   int results_done = 0;
   int errors = 0;
   int cycle_count = 0;
   int req_hold = 0;
   int rsp_hold = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   sphere_frustum_distance_cull dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      // center_x, center_y, center_z, radius from bit 0 upwards, then zero padding.
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      // clip_class, in_range, visible from bit 0 upwards, then zero padding.
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Classifies one sphere against the register copy. Plane distances are exact in Q.12:
   // a distance below minus the scaled radius is outside, below plus the radius is crossing.
   // The draw test compares squared camera distance less radius squared with the limit.
   function automatic verdict_type cull_verdict(sphere_type s);
      longint reach, plane_dist, dx, dy, dz, span_sq;
      logic signed [NB-1:0] nx, ny, nz;
      logic signed [OB-1:0] offset;
      logic signed [CB-1:0] eye_x, eye_y, eye_z;
      bit outside, crossing;
      verdict_type v;
      outside = 1'b0;
      crossing = 1'b0;
      reach = longint'(s.radius) * longint'(UNIT_NORMAL);
      for (int k = 0; k < PLANES; k++) begin
         {offset, nz, ny, nx} = plane_cfg[k];
         plane_dist = longint'(nx) * longint'(s.cx) + longint'(ny) * longint'(s.cy)
                    + longint'(nz) * longint'(s.cz) + longint'(offset) * longint'(UNIT_NORMAL);
         if (plane_dist < -reach) begin
            outside = 1'b1;
         end else if (plane_dist < reach) begin
            crossing = 1'b1;
         end
      end
      {eye_z, eye_y, eye_x} = camera_cfg;
      dx = longint'(s.cx) - longint'(eye_x);
      dy = longint'(s.cy) - longint'(eye_y);
      dz = longint'(s.cz) - longint'(eye_z);
      span_sq = dx * dx + dy * dy + dz * dz - longint'(s.radius) * longint'(s.radius);
      v.in_range = span_sq < longint'(draw_cfg);
      v.clip_class = outside ? sfdc_pkg::CLASS_OUTSIDE
                   : (crossing ? sfdc_pkg::CLASS_CROSSING : sfdc_pkg::CLASS_INSIDE);
      v.visible = v.in_range && !outside;
      return v;
   endfunction

   // Wait before the next request or after a response; now and then the side switches
   // between random gaps and a quiet stretch with none at all.
   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 47) == 0) begin
         quiet = !quiet;
      end
      return quiet ? 0 : int'($urandom_range(0, 16));
   endfunction

   function automatic logic [sfdc_pkg::PLANE_BITS-1:0] plane_word(int nx, int ny, int nz,
                                                                  int offset);
      return {offset[OB-1:0], nz[NB-1:0], ny[NB-1:0], nx[NB-1:0]};
   endfunction

   function automatic logic [IB-1:0] plane_reg(int k);
      return CSR_PLANE_FIRST + IB'(k);
   endfunction

   // Request driver: a new request goes out once the last one is taken and its gap is over.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdicts_due.push_back(cull_verdict(sphere_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_hold--;
               req_tvalid <= 1'b0;
            end else if (spheres_to_send.size() > 0) begin
               sphere_on_bus = spheres_to_send.pop_front();
               req_tdata <= sfdc_pkg::REQ_DATA_BITS'({sphere_on_bus.radius, sphere_on_bus.cz,
                                                      sphere_on_bus.cy, sphere_on_bus.cx});
               req_tvalid <= 1'b1;
               req_hold = draw_wait(req_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each response is checked against the oldest outstanding verdict,
   // and the receiver then stalls for a random wait, or not at all in a quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_done++;
            if (verdicts_due.size() == 0) begin
               errors++;
               $display("%0t: response %h with no request outstanding", $time, rsp_tdata);
            end else begin
               verdict_head = verdicts_due.pop_front();
               if (rsp_tdata[1:0] !== verdict_head.clip_class) begin
                  errors++;
                  $display("%0t: clip_class expected %0d, got %0d", $time,
                           verdict_head.clip_class, rsp_tdata[1:0]);
               end
               if (rsp_tdata[2] !== verdict_head.in_range) begin
                  errors++;
                  $display("%0t: in_range expected %0d, got %0d", $time,
                           verdict_head.in_range, rsp_tdata[2]);
               end
               if (rsp_tdata[3] !== verdict_head.visible) begin
                  errors++;
                  $display("%0t: visible expected %0d, got %0d", $time,
                           verdict_head.visible, rsp_tdata[3]);
               end
            end
            rsp_hold = draw_wait(rsp_quiet);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_sphere(int x, int y, int z, int r);
      sphere_type s;
      s.cx = x[CB-1:0];
      s.cy = y[CB-1:0];
      s.cz = z[CB-1:0];
      s.radius = r[RB-1:0];
      spheres_to_send.push_back(s);
      spheres_queued++;
   endtask

   // One register write; the bench's copy follows only what the block keeps.
   task automatic write_reg(logic [IB-1:0] index, logic [DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index < CSR_CAMERA) begin
         plane_cfg[index] = data;
      end else if (index == CSR_CAMERA) begin
         camera_cfg = data[sfdc_pkg::CAMERA_BITS-1:0];
      end else if (index == CSR_DRAW_LIMIT) begin
         draw_cfg = data[sfdc_pkg::DRAW_BITS-1:0];
      end
   endtask

   // Every request has exactly one response, so the block is idle once the counts agree.
   task automatic wait_idle();
      while (results_done != spheres_queued) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Either a box around the origin from near-axis planes with offsets about the scale,
   // or planes and a draw limit of arbitrary bits. The camera sits within the scale and
   // the box's limit is up to six squared scales so both draw range outcomes turn up often.
   task automatic set_random_frustum(int scale, bit skewed);
      int n [3];
      int offset, ex, ey, ez;
      longint limit;
      for (int k = 0; k < PLANES; k++) begin
         if (skewed) begin
            write_reg(plane_reg(k), {$urandom, $urandom});
         end else begin
            for (int a = 0; a < 3; a++) begin
               n[a] = int'($urandom_range(0, 256)) - 128;
            end
            n[(k / 2) % 3] = ((k % 2) ? -UNIT_NORMAL : UNIT_NORMAL) + 4 * n[(k / 2) % 3];
            offset = int'($urandom_range(0, 2 * scale)) - scale / 2;
            write_reg(plane_reg(k), plane_word(n[0], n[1], n[2], offset));
         end
      end
      ex = int'($urandom_range(0, 2 * scale)) - scale;
      ey = int'($urandom_range(0, 2 * scale)) - scale;
      ez = int'($urandom_range(0, 2 * scale)) - scale;
      write_reg(CSR_CAMERA, {1'($urandom), ez[CB-1:0], ey[CB-1:0], ex[CB-1:0]});
      limit = longint'(scale) * longint'(scale) * longint'($urandom_range(0, 6))
            + longint'($urandom_range(0, scale));
      if (skewed) begin
         write_reg(CSR_DRAW_LIMIT, {$urandom, $urandom});
      end else begin
         write_reg(CSR_DRAW_LIMIT, DATA_BITS'(limit));
      end
      if ($urandom_range(0, 1) == 0) begin
         write_reg(IB'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)),
                   {$urandom, $urandom});
      end
   endtask

   // Mostly spheres around the frustum at the phase's scale; the rest take arbitrary bits
   // in every field.
   task automatic queue_random_spheres(int count, int scale);
      int span;
      span = 2 * scale;
      repeat (count) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_sphere($urandom, $urandom, $urandom, $urandom);
         end else begin
            queue_sphere(int'($urandom_range(0, 2 * span)) - span,
                         int'($urandom_range(0, 2 * span)) - span,
                         int'($urandom_range(0, 2 * span)) - span,
                         $urandom_range(0, scale));
         end
      end
   endtask

   initial begin
      int scale;
      for (int k = 0; k < PLANES; k++) begin
         plane_cfg[k] = '0;
      end
      camera_cfg = '0;
      draw_cfg = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers straight out of reset: all planes give distance zero, so a sphere with
      // radius is crossing and one without is inside; a zero limit only passes spheres
      // that enclose the camera.
      queue_sphere(0, 0, 0, 0);
      queue_sphere(0, 0, 0, 1);
      queue_sphere(-1048576, 1048575, -1048576, 1048575);
      queue_sphere(1048575, 1048575, 1048575, 0);
      queue_sphere(1, -1, 1, 2);
      wait_idle();

      // A box of half width 100 about the origin, camera at the origin, limit 100 squared.
      // Spheres touch planes at exactly minus the radius, sit one unit beyond, and have
      // zero radius at zero distance; others land on and just inside the draw limit.
      write_reg(plane_reg(0), plane_word(UNIT_NORMAL, 0, 0, 100));
      write_reg(plane_reg(1), plane_word(-UNIT_NORMAL, 0, 0, 100));
      write_reg(plane_reg(2), plane_word(0, UNIT_NORMAL, 0, 100));
      write_reg(plane_reg(3), plane_word(0, -UNIT_NORMAL, 0, 100));
      write_reg(plane_reg(4), plane_word(0, 0, UNIT_NORMAL, 100));
      write_reg(plane_reg(5), plane_word(0, 0, -UNIT_NORMAL, 100));
      write_reg(CSR_CAMERA, '0);
      write_reg(CSR_DRAW_LIMIT, DATA_BITS'(10000));
      write_reg(CSR_UNMAPPED_FIRST, '1);
      write_reg(CSR_UNMAPPED_LAST, '1);
      queue_sphere(-101, 0, 0, 1);
      queue_sphere(-102, 0, 0, 1);
      queue_sphere(-100, 0, 0, 0);
      queue_sphere(0, 0, 0, 5);
      queue_sphere(99, 0, 0, 0);
      queue_sphere(100, 0, 0, 1);
      queue_sphere(0, 0, -100, 0);
      queue_sphere(50, -50, 50, 200);
      queue_sphere(0, 0, 0, 1048575);
      wait_idle();

      // Field extremes in the registers: planes of all ones, largest and most negative
      // normals and offsets, a camera of all ones and the widest draw limit.
      write_reg(plane_reg(0), '1);
      write_reg(plane_reg(1), plane_word(8191, 8191, 8191, 2097151));
      write_reg(plane_reg(2), plane_word(-8192, -8192, -8192, -2097152));
      write_reg(plane_reg(3), plane_word(8191, -8192, 0, 0));
      write_reg(plane_reg(4), '0);
      write_reg(plane_reg(5), plane_word(0, 0, 0, -2097152));
      write_reg(CSR_CAMERA, '1);
      write_reg(CSR_DRAW_LIMIT, '1);
      queue_sphere(-1048576, -1048576, -1048576, 1048575);
      queue_sphere(1048575, 1048575, 1048575, 0);
      queue_sphere(-1048576, 1048575, 0, 1);
      queue_sphere(0, 0, 0, 0);
      queue_sphere(1048575, -1048576, 1048575, 1048575);
      wait_idle();

      // Random phases over scales from a few units to the full coordinate range.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         scale = 1 << $urandom_range(3, 20);
         set_random_frustum(scale, (phase % 4) == 3);
         queue_random_spheres(PHASE_SPHERES, scale);
         wait_idle();
      end

      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/sfdc_pkg.sv
hw/rtl/sfdc_range.sv
hw/rtl/sfdc_cell.sv
hw/rtl/sphere_frustum_distance_cull.sv
hw/rtl/sfdc_checker.sv
bench/tb.sv
